[rtl/core/lrukv_pkg.sv]
// ----------------------------------------------------------------------------
// lrukv_pkg
// Shared types and defaults for the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lrukv_pkg;

  localparam int DEPTH_DEF      = 8;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 64;

  // capacity register
  localparam int          CAP_W     = 4;
  localparam logic [3:0]  CAP_RESET = 4'd8;

  typedef enum logic {
    MODE_GET = 1'b0,
    MODE_PUT = 1'b1
  } lrukv_mode_t;

  typedef struct packed {
    logic hit;
    logic evicted;
  } lrukv_flags_t;

endpackage

`default_nettype wire

[rtl/core/lrukv_if.sv]
// ----------------------------------------------------------------------------
// lrukv_if
// Request and response channels of the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrukv_in_if #(
  parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [KEY_BITS-1:0]   lookup_key;
  logic [VALUE_BITS-1:0] write_value;

  modport source (output valid, mode, lookup_key, write_value, input ready);
  modport sink   (input valid, mode, lookup_key, write_value, output ready);
endinterface

interface lrukv_out_if #(
  parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

[rtl/core/lrukv_core.sv]
// ----------------------------------------------------------------------------
// lrukv_core
// Entry store, parallel key match, recency ranks and replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module lrukv_core #(
  parameter int DEPTH      = lrukv_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         op_en,
  input  wire logic                         op_put,
  input  wire logic [KEY_BITS-1:0]          op_key,
  input  wire logic [VALUE_BITS-1:0]        op_value,
  input  wire logic [lrukv_pkg::CAP_W-1:0]  capacity,
  output lrukv_pkg::lrukv_flags_t           res_flags,
  output logic      [VALUE_BITS-1:0]        res_value,
  output logic      [KEY_BITS-1:0]          res_evicted_key
);

  localparam int RANK_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CW     = (CNT_W > lrukv_pkg::CAP_W) ? CNT_W : lrukv_pkg::CAP_W;

  logic [KEY_BITS-1:0]   keys_r   [DEPTH];
  logic [VALUE_BITS-1:0] values_r [DEPTH];
  logic [RANK_W-1:0]     rank_r   [DEPTH];
  logic [RANK_W-1:0]     rank_nxt [DEPTH];
  logic [DEPTH-1:0]      valid_r, valid_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic [DEPTH-1:0]      match, hit_oh, victim, valid_keep, free, slot_oh;
  logic                  hit, full, do_evict, do_insert;
  logic [RANK_W-1:0]     found_rank, last_rank;
  logic [VALUE_BITS-1:0] hit_value;
  logic [KEY_BITS-1:0]   victim_key;
  logic [CW-1:0]         cap_ext, eff_cap;

  // capacity saturated to 1..DEPTH
  always_comb begin
    cap_ext = CW'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full      = CW'(count_r) >= eff_cap;
  assign last_rank = RANK_W'(count_r - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i]  = valid_r[i] && (keys_r[i] == op_key);
      // valid ranks are always a permutation of 0..count-1
      victim[i] = valid_r[i] && (rank_r[i] == last_rank);
    end
  end

  assign hit      = |match;
  assign hit_oh   = match & (~match + DEPTH'(1));
  assign do_evict = op_put && !hit && full;

  assign valid_keep = valid_r & ~(do_evict ? victim : '0);
  assign free       = ~valid_keep;
  assign slot_oh    = free & (~free + DEPTH'(1));
  assign do_insert  = op_put && !hit && (|free);

  always_comb begin
    found_rank = '0;
    hit_value  = '0;
    victim_key = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found_rank = found_rank | (hit_oh[i] ? rank_r[i] : '0);
      hit_value  = hit_value  | (hit_oh[i] ? values_r[i] : '0);
      victim_key = victim_key | (victim[i] ? keys_r[i] : '0);
    end
  end

  always_comb begin
    res_flags.hit     = hit;
    res_flags.evicted = do_evict;
    res_value         = (hit && !op_put) ? hit_value : '0;
    res_evicted_key   = do_evict ? victim_key : '0;
  end

  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < DEPTH; i++) begin
      rank_nxt[i] = rank_r[i];
      if (hit) begin
        if (valid_r[i] && (rank_r[i] < found_rank)) begin
          rank_nxt[i] = rank_r[i] + RANK_W'(1);
        end
        if (hit_oh[i]) begin
          rank_nxt[i] = '0;
        end
      end else if (op_put) begin
        valid_nxt[i] = valid_keep[i];
        if (do_evict && victim[i]) begin
          rank_nxt[i] = '0;
        end
        if (do_insert) begin
          if (valid_keep[i]) begin
            rank_nxt[i] = rank_r[i] + RANK_W'(1);
          end
          if (slot_oh[i]) begin
            rank_nxt[i]  = '0;
            valid_nxt[i] = 1'b1;
          end
        end
      end
    end
    count_nxt = count_r - CNT_W'(do_evict) + CNT_W'(do_insert);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        rank_r[i] <= '0;
      end
    end else if (op_en) begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < DEPTH; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // entry payload, no reset
  always_ff @(posedge clk) begin
    if (op_en) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (do_insert && slot_oh[i]) begin
          keys_r[i]   <= op_key;
          values_r[i] <= op_value;
        end else if (hit && op_put && hit_oh[i]) begin
          values_r[i] <= op_value;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/lru_key_value_cache.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (valid/ready): mode selects get or put, with a
// key and, for a put, a value. Each request gives exactly one response beat
// on out_ch: hit flag, read value of a get hit, and the evicted key when a
// put of a new key displaces the least recent entry.
// A request is captured in an input register, then matched against all
// entries at once; the response and the new state are registered together.
// The request passes through the input register and then the response
// register before its response beat; one request per cycle is sustained
// while out_ch.ready stays high, the rate being set by the combinational
// parallel match and rank update in lrukv_core.
// When the receiver stalls, the response holds and one more request waits
// in the input register; in_ch.ready then drops until out_ch.ready returns.
// cfg_we/cfg_wdata write the capacity in use (0 acts as 1, above DEPTH acts
// as DEPTH); reset sets it to 8 and empties the cache (valid flags, ranks
// and count cleared, no sweep).
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache #(
  parameter int DEPTH      = lrukv_pkg::DEPTH_DEF,
  parameter int KEY_BITS   = lrukv_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lrukv_pkg::VALUE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  lrukv_in_if.sink                          in_ch,
  lrukv_out_if.source                       out_ch,
  input  wire logic                         cfg_we,
  input  wire logic [lrukv_pkg::CAP_W-1:0]  cfg_wdata
);

  logic                          req_vld_r;
  logic                          req_mode_r;
  logic [KEY_BITS-1:0]           req_key_r;
  logic [VALUE_BITS-1:0]         req_value_r;
  logic [lrukv_pkg::CAP_W-1:0]   cap_r;

  logic                          rsp_vld_r;
  lrukv_pkg::lrukv_flags_t       rsp_flags_r;
  logic [VALUE_BITS-1:0]         rsp_value_r;
  logic [KEY_BITS-1:0]           rsp_ev_key_r;

  lrukv_pkg::lrukv_flags_t       res_flags;
  logic [VALUE_BITS-1:0]         res_value;
  logic [KEY_BITS-1:0]           res_ev_key;
  logic                          advance;

  assign advance     = req_vld_r && (!rsp_vld_r || out_ch.ready);
  assign in_ch.ready = !req_vld_r || advance;

  lrukv_core #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .op_en           (advance),
    .op_put          (req_mode_r == lrukv_pkg::MODE_PUT),
    .op_key          (req_key_r),
    .op_value        (req_value_r),
    .capacity        (cap_r),
    .res_flags       (res_flags),
    .res_value       (res_value),
    .res_evicted_key (res_ev_key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lrukv_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      req_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_mode_r  <= in_ch.mode;
      req_key_r   <= in_ch.lookup_key;
      req_value_r <= in_ch.write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_vld_r <= 1'b0;
    end else if (advance) begin
      rsp_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      rsp_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_flags_r  <= res_flags;
      rsp_value_r  <= res_value;
      rsp_ev_key_r <= res_ev_key;
    end
  end

  assign out_ch.valid       = rsp_vld_r;
  assign out_ch.hit         = rsp_flags_r.hit;
  assign out_ch.read_value  = rsp_value_r;
  assign out_ch.evicted     = rsp_flags_r.evicted;
  assign out_ch.evicted_key = rsp_ev_key_r;

endmodule

`default_nettype wire

[verif/lru_key_value_cache_tb.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Self-checking bench for the LRU key-value cache. A shadow copy of the
// entries, ranks and count predicts hit, read value and eviction for every
// request beat. Response beats are compared in order against that prediction.
// Directed gets and puts come first. Random traffic from a small key pool
// follows, so hits and evictions are frequent, over several capacity
// settings and idle patterns. A long receiver stall fills the block last.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        hit;
    logic [63:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lru_response_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [lrukv_pkg::CAP_W-1:0]     cfg_wdata;

  lrukv_in_if  in_ch ();
  lrukv_out_if out_ch ();

  lru_key_value_cache DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the cache contents
  logic [31:0]                 shadow_key   [lrukv_pkg::DEPTH_DEF];
  logic [63:0]                 shadow_value [lrukv_pkg::DEPTH_DEF];
  logic                        shadow_valid [lrukv_pkg::DEPTH_DEF];
  int                          shadow_rank  [lrukv_pkg::DEPTH_DEF];
  int                          shadow_count;
  logic [lrukv_pkg::CAP_W-1:0] shadow_cap;

  lru_response_t    pending_responses[$];
  logic [31:0]      key_pool[16];

  int unsigned      src_idle_pct;
  int unsigned      sink_idle_pct;
  int               stall_cycles;
  int               errors;
  int               responses_seen;
  int               hits_seen;
  int               evictions_seen;
  int               cap_writes;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  // Predict one access and update the shadow state.
  function automatic lru_response_t predict_lru_access(input lrukv_pkg::lrukv_mode_t op,
                                                       input logic [31:0] key,
                                                       input logic [63:0] value);
    lru_response_t rsp;
    int found;
    int victim;
    int slot;
    int cap_eff;
    int old_rank;
    rsp   = '0;
    found = -1;
    for (int i = 0; i < lrukv_pkg::DEPTH_DEF; i++)
      if (shadow_valid[i] && shadow_key[i] == key && found < 0) found = i;

    if (found >= 0) begin
      rsp.hit  = 1'b1;
      old_rank = shadow_rank[found];
      for (int i = 0; i < lrukv_pkg::DEPTH_DEF; i++)
        if (shadow_valid[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
      shadow_rank[found] = 0;
      if (op == lrukv_pkg::MODE_PUT) shadow_value[found] = value;
      else rsp.read_value = shadow_value[found];
    end else if (op == lrukv_pkg::MODE_PUT) begin
      cap_eff = (shadow_cap == 0) ? 1 :
                (shadow_cap > lrukv_pkg::DEPTH_DEF) ? lrukv_pkg::DEPTH_DEF : int'(shadow_cap);
      if (shadow_count >= cap_eff && shadow_count > 0) begin
        victim = -1;
        for (int i = 0; i < lrukv_pkg::DEPTH_DEF; i++)
          if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
            victim = i;
        if (victim >= 0) begin
          rsp.evicted         = 1'b1;
          rsp.evicted_key     = shadow_key[victim];
          shadow_valid[victim] = 1'b0;
          shadow_rank[victim]  = 0;
          shadow_count--;
        end
      end
      slot = -1;
      for (int i = 0; i < lrukv_pkg::DEPTH_DEF; i++)
        if (!shadow_valid[i] && slot < 0) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < lrukv_pkg::DEPTH_DEF; i++)
          if (shadow_valid[i]) shadow_rank[i]++;
        shadow_key[slot]   = key;
        shadow_value[slot] = value;
        shadow_valid[slot] = 1'b1;
        shadow_rank[slot]  = 0;
        shadow_count++;
      end
    end
    return rsp;
  endfunction

  // Response check first, then prediction of the request beat on the same edge.
  always @(posedge clk) begin
    lru_response_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      responses_seen++;
      if (out_ch.hit === 1'b1) hits_seen++;
      if (out_ch.evicted === 1'b1) evictions_seen++;
      if (pending_responses.size() == 0) begin
        $error("response beat with no request outstanding");
        errors++;
      end else begin
        want = pending_responses.pop_front();
        if (out_ch.hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, out_ch.hit);
          errors++;
        end
        if (out_ch.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_ch.read_value);
          errors++;
        end
        if (out_ch.evicted !== want.evicted) begin
          $error("evicted: expected %0b, got %0b", want.evicted, out_ch.evicted);
          errors++;
        end
        if (out_ch.evicted_key !== want.evicted_key) begin
          $error("evicted_key: expected %h, got %h", want.evicted_key, out_ch.evicted_key);
          errors++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready)
      pending_responses.push_back(
        predict_lru_access(lrukv_pkg::lrukv_mode_t'(in_ch.mode),
                           in_ch.lookup_key, in_ch.write_value));
  end

  // Receiver: random idling, plus an optional long hold-off counted down here.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_cycles > 0) begin
        out_ch.ready = 1'b0;
        stall_cycles--;
      end else begin
        out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_request(input lrukv_pkg::lrukv_mode_t op, input logic [31:0] key,
                              input logic [63:0] value);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.mode        = op;
    in_ch.lookup_key  = key;
    in_ch.write_value = value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random_request(input int key_span);
    logic [31:0] key;
    lrukv_pkg::lrukv_mode_t op;
    op = lrukv_pkg::lrukv_mode_t'($urandom_range(1));
    if ($urandom_range(9) < 8) key = key_pool[$urandom_range(key_span - 1)];
    else key = $urandom;
    send_request(op, key, {$urandom, $urandom});
  endtask

  // Stop offering beats and wait until every response is back.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [lrukv_pkg::CAP_W-1:0] cap);
    drain();
    cfg_we     = 1'b1;
    cfg_wdata  = cap;
    shadow_cap = cap;
    cap_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_basic_operations();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_request(lrukv_pkg::MODE_GET, 32'h0, 64'h0);          // lookup on empty cache
    send_request(lrukv_pkg::MODE_PUT, 32'h0, 64'h0);
    send_request(lrukv_pkg::MODE_PUT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(lrukv_pkg::MODE_GET, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(lrukv_pkg::MODE_GET, 32'hFFFF_FFFF, 64'h0);
    // overwrite present key
    send_request(lrukv_pkg::MODE_PUT, 32'h0, 64'hA5A5_5A5A_0F0F_F0F0);
    send_request(lrukv_pkg::MODE_GET, 32'h0, 64'h0);
    for (int k = 1; k <= 6; k++)
      send_request(lrukv_pkg::MODE_PUT, k, {$urandom, $urandom});   // fills all entries
    send_request(lrukv_pkg::MODE_GET, 32'hFFFF_FFFF, 64'h0);  // key 0 is now least recent
    send_request(lrukv_pkg::MODE_PUT, 32'h7, 64'h1);          // evicts key 0
    send_request(lrukv_pkg::MODE_GET, 32'h0, 64'h0);
    send_request(lrukv_pkg::MODE_PUT, 32'h0, 64'h2);
    // capacity 0 acts as 1 and sits below the occupied count
    set_capacity(4'd0);
    send_request(lrukv_pkg::MODE_PUT, 32'h100, 64'h3);
    send_request(lrukv_pkg::MODE_PUT, 32'h101, 64'h4);
    send_request(lrukv_pkg::MODE_GET, 32'h100, 64'h0);
    send_request(lrukv_pkg::MODE_GET, 32'h101, 64'h0);
    // above DEPTH acts as DEPTH
    set_capacity(4'd15);
    send_request(lrukv_pkg::MODE_PUT, 32'h200, 64'h5);
    send_request(lrukv_pkg::MODE_PUT, 32'h201, 64'h6);
    send_request(lrukv_pkg::MODE_GET, 32'h200, 64'h0);
    drain();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                     input logic [lrukv_pkg::CAP_W-1:0] cap, input int beats);
    int span;
    set_capacity(cap);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    span = (cap == 0) ? 4 :
           (cap > lrukv_pkg::DEPTH_DEF) ? lrukv_pkg::DEPTH_DEF + 4 : int'(cap) + 4;
    for (int n = 0; n < beats; n++) begin
      // bursts without any idling now and then
      if (n % 100 == 50) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (n % 100 == 70) begin
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
      end
      send_random_request(span);
    end
    drain();
  endtask

  task automatic test_input_backpressure();
    set_capacity(4'd6);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    @(posedge clk);
    stall_cycles = 200;
    for (int n = 0; n < 40; n++) send_random_request(10);
    drain();
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = lrukv_pkg::MODE_GET;
    in_ch.lookup_key  = '0;
    in_ch.write_value = '0;
    src_idle_pct      = 0;
    sink_idle_pct     = 0;
    stall_cycles      = 0;
    errors            = 0;
    responses_seen    = 0;
    hits_seen         = 0;
    evictions_seen    = 0;
    cap_writes        = 0;
    for (int i = 0; i < lrukv_pkg::DEPTH_DEF; i++) begin
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i]  = 0;
    end
    shadow_count = 0;
    shadow_cap   = lrukv_pkg::CAP_RESET;
    key_pool[0]  = 32'h0;
    key_pool[1]  = 32'hFFFF_FFFF;
    for (int i = 2; i < 16; i++) key_pool[i] = $urandom;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_basic_operations();
    test_random_traffic(30, 84, 4'd3, 250);
    test_random_traffic(30, 84, 4'd15, 250);
    test_random_traffic(84, 30, 4'd1, 250);
    test_random_traffic(84, 30, 4'd0, 250);
    test_random_traffic(0, 0, 4'd8, 250);
    test_random_traffic(0, 0, 4'd5, 250);
    test_input_backpressure();

    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d response beats: %0d hits, %0d evictions.",
             responses_seen, hits_seen, evictions_seen);
    $display("Capacity written %0d times, from 0 to 15, with idling and a long stall.",
             cap_writes);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/lrukv_pkg.sv
rtl/core/lrukv_if.sv
rtl/core/lrukv_core.sv
rtl/core/lru_key_value_cache.sv
verif/lru_key_value_cache_tb.sv
